// ----- hw/rtl/lru_pkg.sv -----
// Shared types, constants and helpers for the LRU page frame store.
package lru_pkg;

  localparam int FRAME_SLOTS = 32;
  localparam int PAGE_W      = 16;
  localparam int FRAME_W     = $clog2(FRAME_SLOTS);
  localparam int RANK_W      = $clog2(FRAME_SLOTS);
  localparam int CNT_W       = 32;
  localparam int FIU_W       = 6;

  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(4);

  typedef logic [FRAME_SLOTS-1:0] frame_vec_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              new_run;
  } lru_req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [CNT_W-1:0]   fault_total;
    logic [CNT_W-1:0]   hit_total;
  } lru_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // latch request, clear run state if new_run is set
    logic search;  // register match, empty and oldest vectors
    logic commit;  // update frame state and load the result register
  } lru_cmd_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [FRAME_W-1:0] lowest_set(input frame_vec_t v);
    logic [FRAME_W-1:0] idx;
    idx = '0;
    for (int j = FRAME_SLOTS - 1; j >= 0; j--) begin
      if (v[j]) begin
        idx = FRAME_W'(j);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/lru_ctrl.sv -----
// Sequencing of one request through search and update, plus result valid.
module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lru_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       can_commit;
  logic       accept;

  assign can_commit = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) || ((state == S_UPDATE) && can_commit);
  assign accept     = in_valid && in_ready;

  assign cmd.take   = accept;
  assign cmd.search = (state == S_SEARCH);
  assign cmd.commit = (state == S_UPDATE) && can_commit;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold while the previous result is still waiting
        if (can_commit) state_next = accept ? S_SEARCH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/lru_dpath.sv -----
// Frame tags, recency ranks, counters, frame count register and result register.
module lru_dpath
  import lru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lru_cmd_t         cmd,
  input  lru_req_t         in_req,
  input  logic             cfg_we,
  input  logic [FIU_W-1:0] cfg_data,
  output lru_res_t         out_res
);

  logic [PAGE_W-1:0] page [FRAME_SLOTS];
  logic [RANK_W-1:0] rank [FRAME_SLOTS];
  frame_vec_t        valid;
  logic [CNT_W-1:0]  fault_count;
  logic [CNT_W-1:0]  hit_count;
  logic [FIU_W-1:0]  frames_in_use;
  logic [PAGE_W-1:0] req_page;

  // search stage registers
  frame_vec_t match_vec;
  frame_vec_t empty_vec;
  frame_vec_t oldest_vec;

  logic [FIU_W-1:0]   active;
  frame_vec_t         active_mask;
  frame_vec_t         match_comb;
  frame_vec_t         cand;
  frame_vec_t         hi;

  logic               hit;
  logic               has_empty;
  logic               evict;
  logic               age_all;
  logic [FRAME_W-1:0] f;
  logic [RANK_W-1:0]  old_rank;
  logic [CNT_W-1:0]   fault_next;
  logic [CNT_W-1:0]   hit_next;

  always_comb begin
    if (frames_in_use == '0) begin
      active = FIU_W'(1);
    end else if (frames_in_use > FIU_W'(FRAME_SLOTS)) begin
      active = FIU_W'(FRAME_SLOTS);
    end else begin
      active = frames_in_use;
    end
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      active_mask[j] = FIU_W'(j) < active;
      match_comb[j]  = active_mask[j] && valid[j] && (page[j] == req_page);
    end
  end

  // Narrow to the active frames with the largest rank, one rank bit a step.
  always_comb begin
    cand = active_mask;
    hi   = '0;
    for (int b = RANK_W - 1; b >= 0; b--) begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        hi[j] = cand[j] & rank[j][b];
      end
      if (|hi) cand = hi;
    end
  end

  always_comb begin
    hit       = |match_vec;
    has_empty = |empty_vec;
    evict     = !hit && !has_empty;
    age_all   = !hit && has_empty;
    priority if (hit) begin
      f = lowest_set(match_vec);
    end else if (has_empty) begin
      f = lowest_set(empty_vec);
    end else begin
      f = lowest_set(oldest_vec);
    end
    old_rank   = rank[f];
    fault_next = fault_count;
    hit_next   = hit_count;
    if (hit) begin
      if (hit_count != '1) hit_next = hit_count + CNT_W'(1);
    end else begin
      if (fault_count != '1) fault_next = fault_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_data;
    end
    if (cmd.take) req_page <= in_req.page;
    if (cmd.search) begin
      match_vec  <= match_comb;
      empty_vec  <= active_mask & ~valid;
      oldest_vec <= cand;
    end
    if (cmd.commit) begin
      if (!hit) page[f] <= req_page;
      out_res.hit          <= hit;
      out_res.frame        <= f;
      out_res.evicted      <= evict;
      out_res.evicted_page <= evict ? page[f] : '0;
      out_res.fault_total  <= fault_next;
      out_res.hit_total    <= hit_next;
    end
    // a new run empties the store before its own reference is searched
    if (rst || (cmd.take && in_req.new_run)) begin
      valid       <= '0;
      fault_count <= '0;
      hit_count   <= '0;
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        rank[j] <= '0;
      end
    end else if (cmd.commit) begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        if (FRAME_W'(j) == f) begin
          rank[j] <= '0;
        end else if (valid[j] && (age_all || (rank[j] < old_rank))) begin
          rank[j] <= rank[j] + RANK_W'(1);
        end
      end
      if (!hit) valid[f] <= 1'b1;
      fault_count <= fault_next;
      hit_count   <= hit_next;
    end
  end

endmodule

// ----- hw/rtl/lru_page_replacement.sv -----
// Top level of the fully associative LRU page frame store.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   request  | in_valid / in_ready   | in_req  (page, new_run)
//   result   | out_valid / out_ready | out_res (hit, frame, evicted, ...)
//   config   | cfg_we                | cfg_data (frames_in_use)
//
// Each request passes through a search state (tag compare, empty scan,
// oldest-rank scan) and an update state (rank aging, fill, counters).
// No new request is accepted while the previous one is in its search state.
// A result not taken stalls the update state; the next request is still
// accepted in the cycle that its predecessor commits.
// Reset is synchronous; the frame store needs no clearing pass.
module lru_page_replacement
  import lru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lru_req_t         in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output lru_res_t         out_res,
  input  logic             cfg_we,
  input  logic [FIU_W-1:0] cfg_data
);

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lru_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_req   (in_req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_res  (out_res)
  );

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while a result is still held");

  a_take_then_search: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> cmd.search)
    else $error("accepted request not searched next cycle");

  a_search_single: assert property (@(posedge clk) disable iff (rst)
    cmd.search |-> !cmd.take && !cmd.commit)
    else $error("search overlaps take or commit");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.evicted |-> !out_res.hit)
    else $error("eviction reported on a hit");

endmodule
